@@ hdl/fwrbk_pkg.sv @@
package fwrbk_pkg;

  localparam int STATUS_W  = 3;
  localparam int CNT_OUT_W = 5;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic scan;
    logic shift;
    logic write;
  } ctl_t;

endpackage

@@ hdl/fwrbk_cell.sv @@
module fwrbk_cell #(
  parameter int KEY_WIDTH = 16,
  parameter int CNT_W     = 5,
  parameter int POS_W     = 4,
  parameter int INDEX     = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fwrbk_pkg::ctl_t      ctl,
  input  logic [CNT_W-1:0]     count,
  input  logic [POS_W-1:0]     pos,
  input  logic [KEY_WIDTH-1:0] key,
  input  logic                 tok_in,
  input  logic [KEY_WIDTH-1:0] nbr_data,
  output logic [KEY_WIDTH-1:0] data,
  output logic                 tok,
  output logic                 hit,
  output logic                 pass
);
  import fwrbk_pkg::*;

  logic match;

  assign match = (data == key);
  assign hit   = tok & match;
  // search token moves on to the next cell unless this one matches
  assign pass  = tok & ~match & ctl.scan;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else begin
      tok <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.write && (count == CNT_W'(INDEX))) begin
      data <= key;
    end else if (ctl.shift && (POS_W'(INDEX) >= pos)) begin
      // close the gap left by the removed entry
      data <= nbr_data;
    end
  end

endmodule

@@ hdl/fifo_with_remove_by_key_unit.sv @@
// Bounded order-keeping queue of keys with removal by key. A word with mode
// insert appends its key at the tail (status full when CAPACITY entries are
// held); a word with mode remove searches from the head for the first equal
// key, takes it out and closes the gap, reporting its position plus one in
// moves. Every word yields one result word with status and occupancy. The
// entries live in a row of CAPACITY cells; a search token walks one cell per
// clock from the head, and on a match every cell from it to the tail takes its
// neighbour's key at once, in the same clock. An insert or a remove on an empty
// queue goes from S_EXEC straight to S_DONE; any other remove passes through
// S_SCAN until the match, or the last entry held when there is no match, is
// reached. The result is loaded into the output register when that register is
// free, and the input is ready again once the result is loaded. Only one word
// is in work at a time; a finished result waits in the output register while
// the next word is accepted.
module fifo_with_remove_by_key_unit #(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic                               mode,
  input  logic [KEY_WIDTH-1:0]               key,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [fwrbk_pkg::STATUS_W-1:0]     status,
  output logic [fwrbk_pkg::CNT_OUT_W-1:0]    moves,
  output logic [fwrbk_pkg::CNT_OUT_W-1:0]    occupancy
);
  import fwrbk_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int EXT_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]           state;
  logic [CNT_W-1:0]     count;
  logic [POS_W-1:0]     pos;
  logic [KEY_WIDTH-1:0] key_r;
  logic                 mode_r;
  logic [STATUS_W-1:0]  res_status;
  logic [CNT_OUT_W-1:0] res_moves;
  logic [CNT_OUT_W-1:0] res_occ;

  ctl_t                 ctl;
  logic                 start;
  logic                 found;
  logic                 last;
  logic                 full;
  logic [EXT_W-1:0]     moves_ext;
  logic [EXT_W-1:0]     occ_inc_ext;
  logic [EXT_W-1:0]     occ_dec_ext;
  logic [EXT_W-1:0]     occ_ext;

  logic [KEY_WIDTH-1:0] data [CAPACITY];
  logic [KEY_WIDTH-1:0] nbr  [CAPACITY];
  logic [CAPACITY-1:0]  tok;
  logic [CAPACITY-1:0]  hit;
  logic [CAPACITY-1:0]  pass;
  logic [CAPACITY-1:0]  tok_in;

  assign item_stall = (state != S_IDLE);
  assign full       = (count == CNT_W'(CAPACITY));
  assign start      = (state == S_EXEC) && (mode_r == MODE_REMOVE) && (count != '0);
  assign found      = |hit;
  assign last       = (CNT_W'(pos) == count - CNT_W'(1));

  assign ctl.scan  = (state == S_SCAN);
  assign ctl.shift = (state == S_SCAN) && found;
  assign ctl.write = (state == S_EXEC) && (mode_r == MODE_INSERT) && !full;

  assign moves_ext   = EXT_W'(CNT_W'(pos) + CNT_W'(1));
  assign occ_inc_ext = EXT_W'(count + CNT_W'(1));
  assign occ_dec_ext = EXT_W'(count - CNT_W'(1));
  assign occ_ext     = EXT_W'(count);

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign tok_in[g] = start;
      end else begin : g_body
        assign tok_in[g] = pass[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
        assign nbr[g] = data[g];
      end else begin : g_mid
        assign nbr[g] = data[g+1];
      end

      fwrbk_cell #(
        .KEY_WIDTH (KEY_WIDTH),
        .CNT_W     (CNT_W),
        .POS_W     (POS_W),
        .INDEX     (g)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .count    (count),
        .pos      (pos),
        .key      (key_r),
        .tok_in   (tok_in[g]),
        .nbr_data (nbr[g]),
        .data     (data[g]),
        .tok      (tok[g]),
        .hit      (hit[g]),
        .pass     (pass[g])
      );
    end
  endgenerate

  // a held result stays valid through S_DONE, so setting it there is safe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            key_r  <= key;
            mode_r <= mode;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          pos       <= '0;
          res_moves <= '0;
          if (mode_r == MODE_INSERT) begin
            state <= S_DONE;
            if (full) begin
              res_status <= ST_FULL;
              res_occ    <= occ_ext[CNT_OUT_W-1:0];
            end else begin
              count      <= count + CNT_W'(1);
              res_status <= ST_INSERTED;
              res_occ    <= occ_inc_ext[CNT_OUT_W-1:0];
            end
          end else if (count == '0) begin
            state      <= S_DONE;
            res_status <= ST_EMPTY;
            res_occ    <= '0;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (found) begin
            count      <= count - CNT_W'(1);
            res_status <= ST_REMOVED;
            res_moves  <= moves_ext[CNT_OUT_W-1:0];
            res_occ    <= occ_dec_ext[CNT_OUT_W-1:0];
            state      <= S_DONE;
          end else if (last) begin
            res_status <= ST_NOT_FOUND;
            res_occ    <= occ_ext[CNT_OUT_W-1:0];
            state      <= S_DONE;
          end else begin
            pos <= pos + POS_W'(1);
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            status    <= res_status;
            moves     <= res_moves;
            occupancy <= res_occ;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_one_token : assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok))
    else $error("more than one search token in the cell row");

  a_scan_nonempty : assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (count != '0))
    else $error("search running on an empty queue");

  a_remove_count : assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && found) |=> (count == $past(count) - CNT_W'(1)))
    else $error("removal did not lower the fill count");

  a_accept_exec : assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> (state == S_EXEC))
    else $error("accepted word not taken into execution");

endmodule
